@@ hw/rtl/kth_available_select_remove_defines.svh @@
// ----------------------------------------------------------------------------
// kth_available_select_remove_defines
// Assertion macros for the RTL of the count tree select block.
// ----------------------------------------------------------------------------
`ifndef KTH_AVAILABLE_SELECT_REMOVE_DEFINES_SVH
`define KTH_AVAILABLE_SELECT_REMOVE_DEFINES_SVH

// same-cycle implication, gated by an active-low reset
`define KASR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by an active-low reset
`define KASR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kasr_pkg.sv @@
// ----------------------------------------------------------------------------
// kasr_pkg
// Widths, reset values and state type of the count tree select block.
// ----------------------------------------------------------------------------
`default_nettype none

package kasr_pkg;

    localparam int RANK_W = 10;
    localparam int POS_W  = 11;
    localparam int EC_W   = 11;

    localparam logic [EC_W-1:0] EC_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } kasr_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/kth_available_select_remove.sv @@
// ----------------------------------------------------------------------------
// kth_available_select_remove
// Picks and removes the present position with k present positions above it.
// ----------------------------------------------------------------------------
// The pool of positions 1..element_count lives as a binary count tree in one
// RAM. An item walks from the root down, one tree level per cycle: each cycle
// reads the upper child's count, picks a side and writes the chosen child's
// decremented count back. When the walk reaches a leaf the result is loaded
// into the output register, or kept in the hold state while that is busy.
// The next item is taken only in the idle state after the walk, so an item
// is not accepted before the last is through, and later while a finished
// result waits for the output register. The registered RAM read sets the
// pace, one level per cycle. If the rank is not below the remaining count,
// position 1 is returned, removed if present, and out_of_range is set. After
// reset and after every element_count write the tree is rebuilt by a sweep
// of nodes 2..2*TREE_LEAVES-1, one node per cycle, while no item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kth_available_select_remove_defines.svh"

module kth_available_select_remove #(
    parameter int TREE_LEAVES = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [kasr_pkg::EC_W-1:0]   cfg_element_count,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [kasr_pkg::RANK_W-1:0] s_rank_from_top,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [kasr_pkg::POS_W-1:0]  m_position,
    output logic                             m_out_of_range
);

    import kasr_pkg::*;

    localparam int LOG_L = $clog2(TREE_LEAVES);
    localparam int AW    = LOG_L + 1;
    localparam int CW    = LOG_L + 1;
    localparam int KW    = (RANK_W > CW) ? RANK_W : CW;

    localparam logic [AW-1:0] ROOT_NODE  = AW'(1);
    localparam logic [AW-1:0] FIRST_NODE = AW'(2);
    localparam logic [AW-1:0] FIRST_HI   = AW'(3);
    localparam logic [AW-1:0] LAST_NODE  = AW'(2 * TREE_LEAVES - 1);
    localparam logic [CW-1:0] HALF_SPAN  = CW'(TREE_LEAVES / 2);

    function automatic logic [CW-1:0] sat_count(input logic [EC_W-1:0] ec);
        if (32'(ec) > 32'(TREE_LEAVES)) begin
            return CW'(TREE_LEAVES);
        end
        return CW'(ec);
    endfunction

    kasr_state_t state_reg, state_next;

    logic [EC_W-1:0]  element_count_reg, element_count_next;
    logic [CW-1:0]    total_reg, total_next;
    logic             pos1_reg, pos1_next;

    logic [AW-1:0]    sweep_idx_reg, sweep_idx_next;
    logic [CW-1:0]    span_reg, span_next;
    logic [CW-1:0]    start_reg, start_next;

    logic [AW-1:0]    node_reg, node_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             flag_reg, flag_next;
    logic             dec_reg, dec_next;
    logic [POS_W-1:0] res_pos_reg, res_pos_next;

    logic             m_valid_reg, m_valid_next;
    logic [POS_W-1:0] m_position_reg, m_position_next;
    logic             m_oor_reg, m_oor_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CW-1:0]    ram_rdata;

    logic             cfg_acc, in_acc, out_free, load_out, sweep_last, leaf_done;
    logic             go_left;
    logic [AW-1:0]    child;
    logic [CW-1:0]    child_cnt;
    logic [POS_W-1:0] pos_now;
    logic [CW-1:0]    fill_n, fill_diff, fill_val;
    logic             in_flag;

    kasr_ram #(
        .WIDTH(CW),
        .DEPTH(2 * TREE_LEAVES)
    ) u_tree_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // walk step
    assign go_left   = k_reg >= KW'(ram_rdata);
    assign child     = {node_reg[AW-2:0], ~go_left};
    assign child_cnt = go_left ? (cnt_reg - ram_rdata) : ram_rdata;
    assign pos_now   = POS_W'(child[AW-2:0]) + POS_W'(1);

    // refill value of the node under the sweep
    assign fill_n    = sat_count(element_count_reg);
    assign fill_diff = fill_n - start_reg;
    always_comb begin
        if (fill_n <= start_reg) begin
            fill_val = '0;
        end else if (fill_diff >= span_reg) begin
            fill_val = span_reg;
        end else begin
            fill_val = fill_diff;
        end
    end

    assign cfg_acc    = cfg_valid & cfg_ready;
    assign in_acc     = s_valid & s_ready;
    assign out_free   = ~m_valid_reg | m_ready;
    assign sweep_last = (state_reg == ST_SWEEP) && (sweep_idx_reg == LAST_NODE);
    assign leaf_done  = (state_reg == ST_WALK) && child[AW-1];
    assign load_out   = (leaf_done || (state_reg == ST_HOLD)) && out_free;
    assign in_flag    = KW'(s_rank_from_top) >= KW'(total_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (cfg_acc) begin
                    state_next = ST_SWEEP;
                end else if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_acc) begin
                    state_next = ST_SWEEP;
                end else if (in_acc) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (leaf_done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = child;
        ram_wdata = child_cnt - CW'(dec_reg);
        ram_raddr = FIRST_HI;
        unique case (state_reg)
            ST_SWEEP: begin
                cfg_ready = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = sweep_idx_reg;
                ram_wdata = fill_val;
            end
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = ~cfg_valid;
            end
            ST_WALK: begin
                ram_we    = 1'b1;
                ram_raddr = {child[AW-2:0], 1'b1};
            end
            ST_HOLD: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        element_count_next = element_count_reg;
        total_next         = total_reg;
        pos1_next          = pos1_reg;
        sweep_idx_next     = sweep_idx_reg + AW'(1);
        span_next          = span_reg;
        start_next         = start_reg + span_reg;
        node_next          = node_reg;
        cnt_next           = cnt_reg;
        k_next             = k_reg;
        flag_next          = flag_reg;
        dec_next           = dec_reg;
        res_pos_next       = res_pos_reg;
        m_position_next    = m_position_reg;
        m_oor_next         = m_oor_reg;
        m_valid_next       = m_valid_reg & ~m_ready;

        if (((sweep_idx_reg + AW'(1)) & sweep_idx_reg) == '0) begin
            span_next  = span_reg >> 1;
            start_next = '0;
        end

        if (cfg_acc) begin
            element_count_next = cfg_element_count;
            total_next         = sat_count(cfg_element_count);
            pos1_next          = cfg_element_count != '0;
            sweep_idx_next     = FIRST_NODE;
            span_next          = HALF_SPAN;
            start_next         = '0;
        end

        if (in_acc) begin
            node_next = ROOT_NODE;
            cnt_next  = total_reg;
            k_next    = KW'(s_rank_from_top);
            flag_next = in_flag;
            dec_next  = in_flag ? pos1_reg : 1'b1;
        end

        if (state_reg == ST_WALK) begin
            node_next = child;
            cnt_next  = child_cnt;
            k_next    = go_left ? (k_reg - KW'(ram_rdata)) : k_reg;
            if (leaf_done) begin
                total_next   = total_reg - CW'(dec_reg);
                res_pos_next = pos_now;
                if (child[AW-2:0] == '0) begin
                    pos1_next = 1'b0;
                end
            end
        end

        if (load_out) begin
            m_valid_next    = 1'b1;
            m_position_next = (state_reg == ST_HOLD) ? res_pos_reg : pos_now;
            m_oor_next      = flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_SWEEP;
            element_count_reg <= EC_RESET;
            total_reg         <= sat_count(EC_RESET);
            pos1_reg          <= 1'b1;
            sweep_idx_reg     <= FIRST_NODE;
            span_reg          <= HALF_SPAN;
            start_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            element_count_reg <= element_count_next;
            total_reg         <= total_next;
            pos1_reg          <= pos1_next;
            sweep_idx_reg     <= sweep_idx_next;
            span_reg          <= span_next;
            start_reg         <= start_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg       <= node_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        flag_reg       <= flag_next;
        dec_reg        <= dec_next;
        res_pos_reg    <= res_pos_next;
        m_position_reg <= m_position_next;
        m_oor_reg      <= m_oor_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_position     = m_position_reg;
    assign m_out_of_range = m_oor_reg;

    `KASR_ASSERT_IMPL(a_total_bound, aclk, aresetn, 1'b1, 32'(total_reg) <= 32'(TREE_LEAVES), "remaining count above tree size")
    `KASR_ASSERT_IMPL(a_rank_in_node, aclk, aresetn, (state_reg == ST_WALK) && !flag_reg, KW'(cnt_reg) > k_reg, "in-range walk left its subtree")
    `KASR_ASSERT_IMPL(a_leaf_present, aclk, aresetn, leaf_done && !flag_reg, child_cnt == CW'(1), "in-range walk ended on a taken leaf")

endmodule

`default_nettype wire

@@ hw/rtl/kasr_ram.sv @@
// ----------------------------------------------------------------------------
// kasr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kasr_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ tb/pool_pick_checker.sv @@
// ----------------------------------------------------------------------------
// pool_pick_checker
// Tracks the position pool beside the block and checks every returned pick.
// ----------------------------------------------------------------------------
// Keeps its own count tree. A pool write refills it. An accepted rank walks it,
// picks the position and removes it. The expected pick is queued. Each
// returned item is compared field by field with the oldest queued pick.
// ----------------------------------------------------------------------------
module pool_pick_checker
    import kasr_pkg::*;
#(
    parameter int TREE_LEAVES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [EC_W-1:0]   cfg_element_count,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [RANK_W-1:0] s_rank_from_top,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [POS_W-1:0]  m_position,
    input  logic              m_out_of_range,
    output int                mismatch_count,
    output int                picks_pending
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             out_of_range;
    } pick_t;

    logic [POS_W-1:0] pool_count [1:2*TREE_LEAVES-1];
    pick_t            picks_due [$];

    function automatic void refill_pool(input logic [EC_W-1:0] count);
        int n;
        n = (count > TREE_LEAVES) ? TREE_LEAVES : int'(count);
        for (int i = 1; i < 2 * TREE_LEAVES; i++) begin
            pool_count[i] = '0;
        end
        for (int i = 0; i < n; i++) begin
            pool_count[TREE_LEAVES + i] = POS_W'(1);
        end
        for (int i = TREE_LEAVES - 1; i >= 1; i--) begin
            pool_count[i] = pool_count[2*i] + pool_count[2*i+1];
        end
    endfunction

    // ranks at or past the remaining count fall through to position 1
    function automatic pick_t pick_and_remove(input logic [RANK_W-1:0] rank);
        int    k;
        int    node;
        pick_t p;
        k = int'(rank);
        node = 1;
        p.out_of_range = (k >= int'(pool_count[1]));
        while (node < TREE_LEAVES) begin
            if (k >= int'(pool_count[2*node+1])) begin
                k -= int'(pool_count[2*node+1]);
                node = 2 * node;
            end else begin
                node = 2 * node + 1;
            end
        end
        p.position = POS_W'(node - TREE_LEAVES + 1);
        pool_count[node] = '0;
        node = node / 2;
        while (node >= 1) begin
            pool_count[node] = pool_count[2*node] + pool_count[2*node+1];
            node = node / 2;
        end
        return p;
    endfunction

    // only the first 100 are printed
    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        pick_t want;
        if (!aresetn) begin
            refill_pool(EC_RESET);
            picks_due.delete();
            mismatch_count = 0;
            picks_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                refill_pool(cfg_element_count);
            end
            if (s_valid && s_ready) begin
                picks_due.push_back(pick_and_remove(s_rank_from_top));
            end
            if (m_valid && m_ready) begin
                if (picks_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item position=%0d out_of_range=%0b",
                                              m_position, m_out_of_range));
                end else begin
                    want = picks_due.pop_front();
                    if (m_position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  m_position, want.position));
                    end
                    if (m_out_of_range !== want.out_of_range) begin
                        report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                                  m_out_of_range, want.out_of_range));
                    end
                end
            end
            picks_pending <= picks_due.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the kth-available select and remove block.
// ----------------------------------------------------------------------------
// A directed part covers the rank and pool-size extremes, empty pools, ranks
// past the remaining count and an oversized pool size. Random phases follow,
// each after a pool refill, with ranks mostly inside the remaining pool.
// Both channels idle at random except during one calm phase.
// ----------------------------------------------------------------------------
module testbench;

    import kasr_pkg::*;

    localparam int TREE_LEAVES  = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [EC_W-1:0]   cfg_element_count;
    logic              s_valid;
    logic              s_ready;
    logic [RANK_W-1:0] s_rank_from_top;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [POS_W-1:0]  m_position;
    logic              m_out_of_range;

    int mismatch_count;
    int picks_pending;
    int cycle_count = 0;
    int pool_left;
    bit calm = 1'b0;

    kth_available_select_remove #(
        .TREE_LEAVES(TREE_LEAVES)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_element_count (cfg_element_count),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rank_from_top   (s_rank_from_top),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position        (m_position),
        .m_out_of_range    (m_out_of_range)
    );

    pool_pick_checker #(
        .TREE_LEAVES(TREE_LEAVES)
    ) pick_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_element_count (cfg_element_count),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rank_from_top   (s_rank_from_top),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position        (m_position),
        .m_out_of_range    (m_out_of_range),
        .mismatch_count    (mismatch_count),
        .picks_pending     (picks_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** kth_available_select_remove: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // waits until every pick is back, then refills the pool
    task automatic set_pool(input logic [EC_W-1:0] count);
        s_valid <= 1'b0;
        do @(posedge aclk); while (picks_pending != 0);
        cfg_valid <= 1'b1;
        cfg_element_count <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_left = (count > TREE_LEAVES) ? TREE_LEAVES : int'(count);
    endtask

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rank_from_top <= rank;
        do @(posedge aclk); while (!s_ready);
        if (rank < pool_left) begin
            pool_left--;
        end
    endtask

    initial begin
        logic [EC_W-1:0]   phase_counts [10];
        logic [EC_W-1:0]   count;
        logic [RANK_W-1:0] rank;
        int                n;

        phase_counts = '{11'd1024, 11'd6, 11'd1, 11'd700, 11'd2047,
                         11'd64, 11'd0, 11'd0, 11'd300, 11'd1024};
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_element_count <= '0;
        s_valid <= 1'b0;
        s_rank_from_top <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        pool_left = TREE_LEAVES;

        // full pool from reset: top pick, ranks past the count, then a middle rank
        send_rank(10'd0);
        send_rank(10'd1023);
        send_rank(10'd1022);
        send_rank(10'd511);

        // single position, then empty
        set_pool(11'd1);
        send_rank(10'd0);
        send_rank(10'd0);
        send_rank(10'd1023);

        set_pool(11'd0);
        send_rank(10'd0);
        send_rank(10'd682);

        // oversized count saturates to a full pool
        set_pool(11'd2047);
        send_rank(10'd1023);
        send_rank(10'd0);
        send_rank(10'd341);

        // position 1 removed by an out-of-range rank, then hit again
        set_pool(11'd3);
        send_rank(10'd5);
        send_rank(10'd0);
        send_rank(10'd0);
        send_rank(10'd0);

        for (int p = 0; p < 10; p++) begin
            count = (p == 7) ? EC_W'($urandom_range(0, 2047)) : phase_counts[p];
            calm <= (p == 3);
            set_pool(count);
            n = (pool_left < 30) ? pool_left + 20 : 110;
            for (int i = 0; i < n; i++) begin
                if (pool_left > 0 && $urandom_range(0, 99) < 85) begin
                    rank = RANK_W'($urandom_range(0, pool_left - 1));
                end else begin
                    rank = RANK_W'($urandom_range(0, 1023));
                end
                send_rank(rank);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (picks_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && picks_pending == 0) begin
            $display("** kth_available_select_remove: PASSED **");
        end else begin
            $display("** kth_available_select_remove: FAILED **");
        end
        $finish;
    end

endmodule
